// ===== hw/rtl/ghash_pkg.sv =====
// ghash accumulator shared types and constants
`timescale 1ns / 1ps

package ghash_pkg;

    localparam int BLOCK_W = 128;
    localparam int HALF_W  = 64;

    // operation codes of the input item
    localparam logic [1:0] OP_CLEAR    = 2'd0;
    localparam logic [1:0] OP_ABSORB   = 2'd1;
    localparam logic [1:0] OP_FINALIZE = 2'd2;

    // configuration register indexes
    localparam logic [0:0] REG_KEY_HI = 1'b0;
    localparam logic [0:0] REG_KEY_LO = 1'b1;

    // what the result stage does with a registered item
    typedef enum logic [1:0] {
        KIND_CLEAR = 2'b01,
        KIND_MULT  = 2'b10,
        KIND_HOLD  = 2'b00
    } item_kind_t;

    typedef struct packed {
        item_kind_t         kind;
        logic [BLOCK_W-1:0] x;     // block xored into the accumulator
        logic [BLOCK_W-1:0] m;     // block xored into the product
    } st_item_t;

endpackage

// ===== hw/rtl/ghash_gfmul.sv =====
// gf(2^128) multiplier in gcm bit order, combinational xor tree
`timescale 1ns / 1ps

module ghash_gfmul (
    input  logic [ghash_pkg::BLOCK_W-1:0] a_in,
    input  logic [ghash_pkg::BLOCK_W-1:0] b_in,
    output logic [ghash_pkg::BLOCK_W-1:0] p_out
);
    import ghash_pkg::*;

    localparam int PROD_W = 2 * BLOCK_W - 1;
    localparam int HI1_W  = PROD_W - BLOCK_W;
    localparam int F1_W   = BLOCK_W + 6;

    // reflected operands: bit i is the coefficient of x^i
    logic [BLOCK_W-1:0] a_r;
    logic [BLOCK_W-1:0] b_r;
    logic [BLOCK_W-1:0] r_r;
    logic [PROD_W-1:0]  prod;
    logic [BLOCK_W-1:0] terms [PROD_W];
    logic [HI1_W-1:0]   hi1;
    logic [F1_W-1:0]    f1;
    logic [5:0]         hi2;

    always_comb begin
        for (int i = 0; i < BLOCK_W; i++) begin
            a_r[i] = a_in[7'(BLOCK_W - 1 - i)];
            b_r[i] = b_in[7'(BLOCK_W - 1 - i)];
        end
    end

    // carry-less product, one parity tree per output bit
    always_comb begin
        for (int k = 0; k < PROD_W; k++) begin
            terms[k] = '0;
            for (int i = 0; i < BLOCK_W; i++) begin
                if (k >= i && k - i < BLOCK_W) begin
                    terms[k][i] = a_r[i] & b_r[7'(k - i)];
                end
            end
            prod[k] = ^terms[k];
        end
    end

    // fold twice with x^128 = x^7 + x^2 + x + 1
    always_comb begin
        hi1 = prod[PROD_W-1:BLOCK_W];
        f1  = {6'b0, prod[BLOCK_W-1:0]}
            ^ {7'b0, hi1}
            ^ {6'b0, hi1, 1'b0}
            ^ {5'b0, hi1, 2'b0}
            ^ {hi1, 7'b0};
        hi2 = f1[F1_W-1:BLOCK_W];
        r_r = f1[BLOCK_W-1:0]
            ^ {122'b0, hi2}
            ^ {121'b0, hi2, 1'b0}
            ^ {120'b0, hi2, 2'b0}
            ^ {115'b0, hi2, 7'b0};
        for (int i = 0; i < BLOCK_W; i++) begin
            p_out[7'(BLOCK_W - 1 - i)] = r_r[i];
        end
    end

endmodule

// ===== hw/rtl/ghash_accumulator.sv =====
// ghash accumulator top level: input stage, gf multiply, accumulator/result stage
`timescale 1ns / 1ps
// an item passes the input register, then the result register, from input transfer to result valid
// throughput: one item per cycle while results are taken; the accumulator feeds back through a single gf(2^128)
//   xor-tree multiplier between the input register and the accumulator register
// reset: synchronous active-low aresetn clears the accumulator, the hash key and both
//   valid flags; the first result after reset starts from a zero accumulator

module ghash_accumulator (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration write port
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_wdata,

    // input item channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic [63:0] s_block_hi,
    input  logic [63:0] s_block_lo,
    input  logic [4:0]  s_block_bytes,
    input  logic [60:0] s_aad_bytes,
    input  logic [60:0] s_text_bytes,
    input  logic [63:0] s_mask_hi,
    input  logic [63:0] s_mask_lo,

    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [63:0] m_digest_hi,
    output logic [63:0] m_digest_lo
);
    import ghash_pkg::*;

    // hash key registers
    logic [HALF_W-1:0]  key_hi_reg;
    logic [HALF_W-1:0]  key_lo_reg;

    // input stage
    st_item_t           st_reg;
    st_item_t           st_next;
    logic               st_valid_reg;

    // result stage: the accumulator doubles as the result payload
    logic [BLOCK_W-1:0] acc_reg;
    logic [BLOCK_W-1:0] acc_next;
    logic               out_valid_reg;

    logic               adv;
    logic               s_xfer;
    logic [BLOCK_W-1:0] keep;
    logic [4:0]         nbytes;
    logic [BLOCK_W-1:0] mul_a;
    logic [BLOCK_W-1:0] mul_p;

    // result stage moves when its slot is free or being drained
    assign adv     = !out_valid_reg || m_ready;
    assign s_ready = !st_valid_reg || adv;
    assign s_xfer  = s_valid && s_ready;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_hi_reg <= '0;
            key_lo_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_KEY_HI: key_hi_reg <= cfg_wdata;
                REG_KEY_LO: key_lo_reg <= cfg_wdata;
                default:    key_hi_reg <= key_hi_reg;
            endcase
        end
    end

    // byte keep mask for a partial block, lengths above sixteen act as sixteen
    always_comb begin
        nbytes = (s_block_bytes > 5'd16) ? 5'd16 : s_block_bytes;
        for (int j = 0; j < 16; j++) begin
            keep[7'(BLOCK_W - 1 - 8 * j) -: 8] = (5'(j) < nbytes) ? 8'hff : 8'h00;
        end
    end

    // decode the item into what the result stage needs
    always_comb begin
        st_next.x = '0;
        st_next.m = '0;
        unique case (s_operation)
            OP_CLEAR: begin
                st_next.kind = KIND_CLEAR;
            end
            OP_ABSORB: begin
                // an empty block leaves the accumulator as it is
                st_next.kind = (s_block_bytes == 5'd0) ? KIND_HOLD : KIND_MULT;
                st_next.x    = {s_block_hi, s_block_lo} & keep;
            end
            OP_FINALIZE: begin
                // length block in bits, then the masking block on top
                st_next.kind = KIND_MULT;
                st_next.x    = {s_aad_bytes, 3'b000, s_text_bytes, 3'b000};
                st_next.m    = {s_mask_hi, s_mask_lo};
            end
            default: begin
                st_next.kind = KIND_HOLD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (s_ready) begin
            st_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            st_reg <= st_next;
        end
    end

    assign mul_a = acc_reg ^ st_reg.x;

    ghash_gfmul u_gfmul (
        .a_in  (mul_a),
        .b_in  ({key_hi_reg, key_lo_reg}),
        .p_out (mul_p)
    );

    always_comb begin
        case (st_reg.kind)
            KIND_CLEAR: acc_next = '0;
            KIND_MULT:  acc_next = mul_p ^ st_reg.m;
            default:    acc_next = acc_reg;
        endcase
    end

    // accumulator and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= st_valid_reg;
            if (st_valid_reg) begin
                acc_reg <= acc_next;
            end
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_digest_hi = acc_reg[BLOCK_W-1:HALF_W];
    assign m_digest_lo = acc_reg[HALF_W-1:0];

    // a held input stage must back-pressure the input channel
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_valid_reg && !adv) |-> !s_ready)
        else $error("input accepted while the input stage is stalled");

    // accumulator only moves when an item enters the result stage
    a_acc_only_on_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !(adv && st_valid_reg) |=> $stable(acc_reg))
        else $error("accumulator changed without an item");

    // a clear item leaves a zero accumulator
    a_clear_zeroes: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && st_valid_reg && st_reg.kind == KIND_CLEAR) |=> (acc_reg == '0))
        else $error("clear did not zero the accumulator");

    // a hold item passes the accumulator through and still yields a result
    a_hold_keeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && st_valid_reg && st_reg.kind == KIND_HOLD) |=> ($stable(acc_reg) && m_valid))
        else $error("hold item altered the accumulator or lost its result");

endmodule

// ===== sim/ghash_accumulator_tb.sv =====
// testbench for the ghash accumulator: queued stimulus, gf(2^128) digest predictor and checker
`timescale 1ns / 1ps

module ghash_accumulator_tb;

    import ghash_pkg::*;

    // opcode with no defined action, the accumulator is just echoed
    localparam logic [1:0] OP_NONE = 2'd3;

    localparam int IDLE_PCT     = 30;    // percent of cycles a side idles
    localparam int STALL_CYCLES = 300;   // long receiver hold-off
    localparam int QUIET_LIMIT  = 3000;  // cycles with no transfer before giving up
    localparam int DRAIN_CYCLES = 8;     // settling wait once nothing is outstanding

    // one input item as the sender sees it
    typedef struct {
        logic [1:0]  op;
        logic [63:0] blk_hi;
        logic [63:0] blk_lo;
        logic [4:0]  nbytes;
        logic [60:0] aad;
        logic [60:0] txt;
        logic [63:0] msk_hi;
        logic [63:0] msk_lo;
    } ghash_item_t;

    // clock, reset and dut ports; every input starts at a known value
    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_we        = 1'b0;
    logic        cfg_index     = REG_KEY_HI;
    logic [63:0] cfg_wdata     = '0;
    logic        s_valid       = 1'b0;
    logic        s_ready;
    logic [1:0]  s_operation   = OP_CLEAR;
    logic [63:0] s_block_hi    = '0;
    logic [63:0] s_block_lo    = '0;
    logic [4:0]  s_block_bytes = '0;
    logic [60:0] s_aad_bytes   = '0;
    logic [60:0] s_text_bytes  = '0;
    logic [63:0] s_mask_hi     = '0;
    logic [63:0] s_mask_lo     = '0;
    logic        m_valid;
    logic        m_ready       = 1'b0;
    logic [63:0] m_digest_hi;
    logic [63:0] m_digest_lo;

    // stimulus waiting for the driver, digests waiting for the dut
    ghash_item_t      pending_q[$];
    logic [127:0]     digest_q[$];

    // predictor state: our own copy of the hash key and the accumulator
    logic [127:0]     key_model = '0;
    logic [127:0]     acc_model = '0;

    ghash_item_t      cur_item;
    logic [127:0]     want;

    int  errors          = 0;
    int  items_sent      = 0;
    int  results_checked = 0;
    int  queued          = 0;
    int  key_settings    = 0;
    int  stall_at        = -1;   // result count at which the long hold-off starts
    bit  stall_done      = 1'b0;
    int  hold_left       = 0;
    bit  calm            = 1'b0; // no random idling on either side while set
    int  quiet           = 0;

    ghash_accumulator dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_operation   (s_operation),
        .s_block_hi    (s_block_hi),
        .s_block_lo    (s_block_lo),
        .s_block_bytes (s_block_bytes),
        .s_aad_bytes   (s_aad_bytes),
        .s_text_bytes  (s_text_bytes),
        .s_mask_hi     (s_mask_hi),
        .s_mask_lo     (s_mask_lo),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_digest_hi   (m_digest_hi),
        .m_digest_lo   (m_digest_lo)
    );

    // 20 ns period
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // product in gf(2^128), gcm bit order: bit 127 of the vector is x^0,
    // a shift right is a multiply by x, reduction folds 0xe1 into the top byte
    function automatic logic [127:0] gf_mult(input logic [127:0] x, input logic [127:0] h);
        logic [127:0] z;
        logic [127:0] v;
        logic         carry;
        z = '0;
        v = h;
        for (int i = 0; i < 128; i++) begin
            if (x[127-i])
                z = z ^ v;
            carry = v[0];
            v = v >> 1;
            if (carry)
                v[127:120] = v[127:120] ^ 8'he1;
        end
        return z;
    endfunction

    // accumulator after one item; it is also the digest the dut reports
    function automatic logic [127:0] ghash_next(input ghash_item_t it, input logic [127:0] acc,
                                                input logic [127:0] key);
        logic [127:0] keep;
        int           n;
        case (it.op)
            OP_CLEAR:
                return '0;
            OP_ABSORB: begin
                n = (it.nbytes > 16) ? 16 : int'(it.nbytes);
                // zero bytes absorbed leave the accumulator unchanged
                if (n == 0)
                    return acc;
                keep = {128{1'b1}} << (8 * (16 - n));
                return gf_mult(acc ^ ({it.blk_hi, it.blk_lo} & keep), key);
            end
            OP_FINALIZE:
                // length block: byte counts become 64-bit bit counts, big-endian
                return gf_mult(acc ^ {it.aad, 3'b000, it.txt, 3'b000}, key)
                       ^ {it.msk_hi, it.msk_lo};
            default:
                return acc;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // driver: offers queued items, predicts each one on its transfer
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            // item accepted at this edge: advance the model, queue its digest
            if (s_valid && s_ready) begin
                acc_model = ghash_next(cur_item, acc_model, key_model);
                digest_q.push_back(acc_model);
                items_sent++;
            end
            if (s_valid && !s_ready) begin
                // offer stands, payload held until the transfer
            end else if (pending_q.size() != 0 &&
                         (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                cur_item       = pending_q.pop_front();
                s_valid       <= 1'b1;
                s_operation   <= cur_item.op;
                s_block_hi    <= cur_item.blk_hi;
                s_block_lo    <= cur_item.blk_lo;
                s_block_bytes <= cur_item.nbytes;
                s_aad_bytes   <= cur_item.aad;
                s_text_bytes  <= cur_item.txt;
                s_mask_hi     <= cur_item.msk_hi;
                s_mask_lo     <= cur_item.msk_lo;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks each result transfer against the oldest digest
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (digest_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t: unexpected digest %h_%h", $realtime,
                                 m_digest_hi, m_digest_lo);
                end else begin
                    want = digest_q.pop_front();
                    if (m_digest_hi !== want[127:64] || m_digest_lo !== want[63:0]) begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t: digest %0d want hi %h lo %h got hi %h lo %h",
                                     $realtime, results_checked, want[127:64], want[63:0],
                                     m_digest_hi, m_digest_lo);
                    end
                end
                results_checked++;
            end
            // one long hold-off so the pipeline fills and s_ready drops
            if (!stall_done && results_checked == stall_at) begin
                stall_done = 1'b1;
                hold_left  = STALL_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= calm || $urandom_range(0, 99) >= IDLE_PCT;
            end
        end
    end

    // watchdog: too long without any transfer on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet <= 0;
        end else if (quiet >= QUIET_LIMIT) begin
            $display("timeout after %0d quiet cycles", quiet);
            $display("ghash_accumulator: mismatch");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic [63:0] rnd64();
        return {$urandom, $urandom};
    endfunction

    // byte counts: mostly small, sometimes full range or the maximum
    function automatic logic [60:0] rnd_len();
        logic [63:0] r;
        r = rnd64();
        case ($urandom_range(0, 5))
            0, 1:    return r[60:0];
            2:       return {61{1'b1}};
            default: return 61'($urandom_range(0, 4096));
        endcase
    endfunction

    function automatic ghash_item_t make_item(input logic [1:0] op, input logic [63:0] bh,
                                              input logic [63:0] bl, input logic [4:0] nb,
                                              input logic [60:0] aad, input logic [60:0] txt,
                                              input logic [63:0] mh, input logic [63:0] ml);
        ghash_item_t it;
        it.op     = op;
        it.blk_hi = bh;
        it.blk_lo = bl;
        it.nbytes = nb;
        it.aad    = aad;
        it.txt    = txt;
        it.msk_hi = mh;
        it.msk_lo = ml;
        return it;
    endfunction

    task automatic queue_item(input ghash_item_t it);
        pending_q.push_back(it);
        queued++;
    endtask

    // idle means nothing pending, nothing offered and nothing outstanding
    task automatic wait_idle();
        do
            @(posedge aclk);
        while (pending_q.size() != 0 || s_valid || digest_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // hash key write, only ever done with the block idle
    task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
        wait_idle();
        @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_KEY_HI;
        cfg_wdata <= hi;
        @(posedge aclk);
        cfg_index <= REG_KEY_LO;
        cfg_wdata <= lo;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        key_model = {hi, lo};
        key_settings++;
    endtask

    // a well-formed message: clear, full blocks, a partial tail, finalize
    task automatic queue_message();
        int nabs;
        nabs = $urandom_range(0, 6);
        queue_item(make_item(OP_CLEAR, rnd64(), rnd64(), 5'($urandom_range(0, 31)),
                             rnd_len(), rnd_len(), rnd64(), rnd64()));
        for (int j = 0; j < nabs; j++)
            queue_item(make_item(OP_ABSORB, rnd64(), rnd64(),
                                 (j == nabs - 1) ? 5'($urandom_range(1, 16)) : 5'd16,
                                 rnd_len(), rnd_len(), rnd64(), rnd64()));
        queue_item(make_item(OP_FINALIZE, rnd64(), rnd64(), 5'($urandom_range(0, 31)),
                             rnd_len(), rnd_len(), rnd64(), rnd64()));
    endtask

    // mostly messages, one in five a raw item with any opcode and byte count
    task automatic queue_random(input int count);
        int start;
        start = queued;
        while (queued - start < count) begin
            if ($urandom_range(0, 4) == 0)
                queue_item(make_item(2'($urandom_range(0, 3)), rnd64(), rnd64(),
                                     5'($urandom_range(0, 31)), rnd_len(), rnd_len(),
                                     rnd64(), rnd64()));
            else
                queue_message();
        end
    endtask

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // identity key (x^0 sits in bit 0 of byte 0): digests are easy to follow
        load_key(64'h8000_0000_0000_0000, 64'h0);
        queue_item(make_item(OP_CLEAR, '1, '1, '1, '1, '1, '1, '1));
        queue_item(make_item(OP_ABSORB, '1, '1, 5'd16, '0, '0, '0, '0));
        queue_item(make_item(OP_ABSORB, '1, '1, 5'd1, '0, '0, '0, '0));
        queue_item(make_item(OP_ABSORB, '1, '1, 5'd8, '0, '0, '0, '0));
        queue_item(make_item(OP_ABSORB, '1, '1, 5'd9, '0, '0, '0, '0));
        queue_item(make_item(OP_ABSORB, '1, '1, 5'd15, '0, '0, '0, '0));
        // zero byte count leaves the accumulator alone
        queue_item(make_item(OP_ABSORB, '1, '1, 5'd0, '0, '0, '0, '0));
        // counts above sixteen act as a full block
        queue_item(make_item(OP_ABSORB, '1, '1, 5'd17, '0, '0, '0, '0));
        queue_item(make_item(OP_ABSORB, '1, '1, 5'd31, '0, '0, '0, '0));
        // undefined opcode echoes the accumulator
        queue_item(make_item(OP_NONE, '1, '1, '1, '1, '1, '1, '1));
        queue_item(make_item(OP_NONE, '0, '0, '0, '0, '0, '0, '0));
        // largest lengths: bit counts reach the top of their 64-bit fields
        queue_item(make_item(OP_FINALIZE, '0, '0, '0, '1, '1, '1, '1));
        queue_item(make_item(OP_FINALIZE, '1, '1, '1, '0, '0, '0, '0));
        queue_item(make_item(OP_CLEAR, '0, '0, '0, '0, '0, '0, '0));
        queue_item(make_item(OP_ABSORB, '0, '0, 5'd16, '1, '1, '1, '1));

        // all-ones key: every reduction step kicks in
        load_key('1, '1);
        queue_item(make_item(OP_ABSORB, '1, '1, 5'd16, '0, '0, '0, '0));
        queue_item(make_item(OP_ABSORB, 64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210,
                             5'd12, '0, '0, '0, '0));
        queue_item(make_item(OP_FINALIZE, '0, '0, '0, 61'd1, 61'd1,
                             64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa));
        queue_item(make_item(OP_FINALIZE, '0, '0, '0, '1, '1, '0, '0));
        queue_item(make_item(OP_CLEAR, '1, '1, '1, '1, '1, '1, '1));
        queue_item(make_item(OP_FINALIZE, '0, '0, '0, '0, '0, '1, '1));

        // random phases under a range of keys
        load_key(rnd64(), rnd64());
        queue_random(250);

        load_key('0, '0);
        queue_random(200);

        // stretch with both sides always ready
        load_key(rnd64(), rnd64());
        wait_idle();
        calm = 1'b1;
        queue_random(250);
        wait_idle();
        calm = 1'b0;

        // receiver holds off for a long while shortly into this phase
        load_key(rnd64(), rnd64());
        stall_at = results_checked + 40;
        queue_random(400);

        load_key('1, rnd64());
        queue_random(330);

        load_key(64'h0, 64'h1);
        queue_random(330);

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("run covered %0d items and %0d checked digests under %0d hash keys",
                 items_sent, results_checked, key_settings);
        $display("directed edge cases, random messages with noise, one long output stall");
        if (errors == 0 && digest_q.size() == 0) begin
            $display("ghash_accumulator: match");
        end else begin
            $display("%0d errors, %0d digests outstanding", errors, digest_q.size());
            $display("ghash_accumulator: mismatch");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
hw/rtl/ghash_pkg.sv
hw/rtl/ghash_gfmul.sv
hw/rtl/ghash_accumulator.sv
sim/ghash_accumulator_tb.sv
